// ----- src/gqsi_pkg.sv -----
// shared types, constants and tables for the quaternion strapdown integrator
// no dependencies; used by gqsi_ctrl, gqsi_datapath and the top level
package gqsi_pkg;

    localparam int RATE_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF = 32;

    localparam logic [31:0] PERIOD_RESET = 32'd42949673;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075408;
    localparam logic signed [35:0] PI_Q32 = 36'sd13493037704;
    localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic [5:0] CORDIC_STAGES = 6'd30;
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] DIV_LAST = 6'd32;
    localparam logic [5:0] REDUCE_STEPS = 6'd5;

    typedef enum logic [3:0] {
        OP_GSQ,
        OP_SQRT,
        OP_ANGLE,
        OP_REDUCE,
        OP_CORDIC,
        OP_AXIS,
        OP_PSCALE,
        OP_QMUL,
        OP_RSQ,
        OP_RNORM
    } op_t;

    typedef struct packed {
        logic load;
        logic start;
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic nrm_zero;
        logic out_free;
    } sts_t;

    // atan(2^-i) in q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // hamilton product: term k of component j subtracts
    function automatic logic qmul_neg(input logic [1:0] j, input logic [1:0] k);
        logic [3:0] m;
        unique case (j)
            2'd0:    m = 4'b1110;
            2'd1:    m = 4'b1000;
            2'd2:    m = 4'b0010;
            default: m = 4'b0100;
        endcase
        return m[k];
    endfunction

endpackage

// ----- src/gyro_quaternion_strapdown_integrator.sv -----
// Strapdown gyroscope integrator: each item carries one three-axis rate sample
// (q8.24 rad/s) and yields the updated orientation quaternion (q2.30). The time
// from acceptance to result is set by the single shared 34x34 multiplier, the
// 32-step square root used twice, the 30-stage cordic and the restoring divider
// run seven times; an item with a zero rate vector stops after the first square
// root. One item is worked at a time; a finished result waits in the output
// register while the next item is taken.
// depends on gqsi_pkg, gqsi_ctrl and gqsi_datapath
module gyro_quaternion_strapdown_integrator
    import gqsi_pkg::*;
#(
    parameter int RATE_WIDTH = RATE_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    localparam int IN_W  = ((3 * RATE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((4 * QUAT_WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,  // sample_period
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,      // gyro_x, gyro_y, gyro_z
    input  logic             s_tuser,      // start_sequence
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata       // quat_w, quat_x, quat_y, quat_z
);

    cmd_t cmd;
    sts_t sts;
    logic in_fire;
    logic [QUAT_WIDTH-1:0] quat_w;
    logic [QUAT_WIDTH-1:0] quat_x;
    logic [QUAT_WIDTH-1:0] quat_y;
    logic [QUAT_WIDTH-1:0] quat_z;

    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = OUT_W'({quat_z, quat_y, quat_x, quat_w});

    gqsi_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .ready   (s_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    gqsi_datapath #(
        .RATE_WIDTH (RATE_WIDTH),
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start_sequence (s_tuser),
        .gyro_x         (s_tdata[RATE_WIDTH-1:0]),
        .gyro_y         (s_tdata[2*RATE_WIDTH-1:RATE_WIDTH]),
        .gyro_z         (s_tdata[3*RATE_WIDTH-1:2*RATE_WIDTH]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .quat_w         (quat_w),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("item taken while previous item in flight");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result overwrote an item not yet taken");

    a_op_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !cmd.load) |-> sts.done)
        else $error("datapath op started before previous op finished");
`endif

endmodule

// ----- src/gqsi_ctrl.sv -----
// sequencer for the quaternion strapdown integrator
// depends on gqsi_pkg; drives gqsi_datapath through cmd_t and sts_t
module gqsi_ctrl
    import gqsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    output logic ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_GSQ    = 13'b0000000000010,
        S_GSQRT  = 13'b0000000000100,
        S_ANGLE  = 13'b0000000001000,
        S_REDUCE = 13'b0000000010000,
        S_CORDIC = 13'b0000000100000,
        S_AXIS   = 13'b0000001000000,
        S_PSCALE = 13'b0000010000000,
        S_QMUL   = 13'b0000100000000,
        S_RSQ    = 13'b0001000000000,
        S_RSQRT  = 13'b0010000000000,
        S_RNORM  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.op     = OP_GSQ;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cmd.start  = 1'b1;
                    cmd.op     = OP_GSQ;
                    state_next = S_GSQ;
                end
            end
            S_GSQ:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    state_next = S_GSQRT;
                end
            end
            S_GSQRT:
            begin
                if (sts.done)
                begin
                    if (sts.nrm_zero)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = OP_ANGLE;
                        state_next = S_ANGLE;
                    end
                end
            end
            S_ANGLE:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_REDUCE;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_CORDIC;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_AXIS;
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_PSCALE;
                    state_next = S_PSCALE;
                end
            end
            S_PSCALE:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_QMUL;
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_RSQ;
                    state_next = S_RSQ;
                end
            end
            S_RSQ:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    state_next = S_RSQRT;
                end
            end
            S_RSQRT:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_RNORM;
                    state_next = S_RNORM;
                end
            end
            S_RNORM:
            begin
                if (sts.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready = (state_reg == S_IDLE);

endmodule

// ----- src/gqsi_datapath.sv -----
// datapath: shared multiplier, integer square root, restoring divider, cordic,
// orientation and output registers; depends on gqsi_pkg, sequenced by gqsi_ctrl
module gqsi_datapath
    import gqsi_pkg::*;
#(
    parameter int RATE_WIDTH = RATE_WIDTH_DEF,
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  start_sequence,
    input  logic [RATE_WIDTH-1:0] gyro_x,
    input  logic [RATE_WIDTH-1:0] gyro_y,
    input  logic [RATE_WIDTH-1:0] gyro_z,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [QUAT_WIDTH-1:0] quat_w,
    output logic [QUAT_WIDTH-1:0] quat_x,
    output logic [QUAT_WIDTH-1:0] quat_y,
    output logic [QUAT_WIDTH-1:0] quat_z
);

    localparam int RSHL = (RATE_WIDTH < 32) ? 32 - RATE_WIDTH : 0;
    localparam int RSHR = (RATE_WIDTH > 32) ? RATE_WIDTH - 32 : 0;
    localparam int QSHL = (QUAT_WIDTH > 32) ? QUAT_WIDTH - 32 : 0;
    localparam int QSHR = (QUAT_WIDTH < 32) ? 32 - QUAT_WIDTH : 0;

    // control
    op_t         op_reg;
    logic        run_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  idx_reg;
    logic        pvld_reg;
    logic [3:0]  pidx_reg;
    logic        m_valid_reg;
    logic [31:0] period_reg;
    logic signed [31:0] q_reg [0:3];

    // payload
    logic signed [31:0] g_reg [0:2];
    logic signed [67:0] prod_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        v_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [38:0]        a_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               neg_reg;
    logic signed [33:0] s_reg;
    logic signed [33:0] p_reg [0:3];
    logic signed [31:0] axis_reg [0:2];
    logic signed [33:0] r_reg [0:3];
    logic [31:0]        rem_reg;
    logic [30:0]        dsh_reg;
    logic [30:0]        qt_reg;
    logic               dneg_reg;
    logic signed [31:0] oq_reg [0:3];

    logic signed [RATE_WIDTH+31:0] gw [0:2];
    logic signed [RATE_WIDTH+31:0] gs [0:2];
    logic signed [31:0] g_in [0:2];
    logic signed [QUAT_WIDTH+31:0] ow [0:3];
    logic signed [QUAT_WIDTH+31:0] os [0:3];

    logic               mul_op;
    logic [5:0]         mul_k;
    logic               done_c;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod_asr;
    logic signed [33:0] prod_sh;
    logic               nrm_zero;
    logic [31:0]        nrm;

    logic [63:0]        sq_trial;
    logic [38:0]        tp_k;
    logic signed [35:0] fa0;
    logic signed [35:0] fa1;
    logic signed [35:0] fa2;
    logic               fneg;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic signed [33:0] dnum;
    logic [33:0]        dmag;
    logic [32:0]        rem2;
    logic [33:0]        ddiff;
    logic signed [31:0] div_res;

    // input rescale to q8.24
    assign gw[0] = {{32{gyro_x[RATE_WIDTH-1]}}, gyro_x};
    assign gw[1] = {{32{gyro_y[RATE_WIDTH-1]}}, gyro_y};
    assign gw[2] = {{32{gyro_z[RATE_WIDTH-1]}}, gyro_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gs[i]   = (gw[i] <<< RSHL) >>> RSHR;
            g_in[i] = gs[i][31:0];
        end
    end

    // output rescale from q2.30
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ow[i] = {{QUAT_WIDTH{oq_reg[i][31]}}, oq_reg[i]};
            os[i] = (ow[i] <<< QSHL) >>> QSHR;
        end
    end

    assign quat_w   = os[0][QUAT_WIDTH-1:0];
    assign quat_x   = os[1][QUAT_WIDTH-1:0];
    assign quat_y   = os[2][QUAT_WIDTH-1:0];
    assign quat_z   = os[3][QUAT_WIDTH-1:0];
    assign m_tvalid = m_valid_reg;

    assign nrm      = root_reg[31:0];
    assign nrm_zero = (root_reg == 64'd0);

    always_comb
    begin
        mul_op = 1'b0;
        mul_k  = 6'd0;
        unique case (op_reg)
            OP_GSQ:    begin mul_op = 1'b1; mul_k = 6'd3;  end
            OP_ANGLE:  begin mul_op = 1'b1; mul_k = 6'd1;  end
            OP_PSCALE: begin mul_op = 1'b1; mul_k = 6'd3;  end
            OP_QMUL:   begin mul_op = 1'b1; mul_k = 6'd16; end
            OP_RSQ:    begin mul_op = 1'b1; mul_k = 6'd4;  end
            default:   begin mul_op = 1'b0; mul_k = 6'd0;  end
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_GSQ, OP_ANGLE, OP_PSCALE, OP_QMUL, OP_RSQ:
                done_c = (cnt_reg == mul_k);
            OP_SQRT:   done_c = (cnt_reg == SQRT_STEPS);
            OP_REDUCE: done_c = (cnt_reg == REDUCE_STEPS);
            OP_CORDIC: done_c = (cnt_reg == CORDIC_STAGES);
            OP_AXIS:   done_c = (cnt_reg == DIV_LAST) && (idx_reg == 2'd2);
            OP_RNORM:  done_c = (cnt_reg == DIV_LAST) && (idx_reg == 2'd3);
            default:   done_c = 1'b0;
        endcase
    end

    assign sts.done     = run_reg & done_c;
    assign sts.nrm_zero = nrm_zero;
    assign sts.out_free = !m_valid_reg || m_tready;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_GSQ:
            begin
                mul_a = 34'(g_reg[cnt_reg[1:0]]);
                mul_b = 34'(g_reg[cnt_reg[1:0]]);
            end
            OP_ANGLE:
            begin
                mul_a = $signed({2'b00, nrm});
                mul_b = $signed({2'b00, period_reg});
            end
            OP_PSCALE:
            begin
                mul_a = s_reg;
                mul_b = 34'(axis_reg[cnt_reg[1:0]]);
            end
            OP_QMUL:
            begin
                mul_a = 34'(q_reg[cnt_reg[1:0]]);
                mul_b = p_reg[cnt_reg[3:2] ^ cnt_reg[1:0]];
            end
            OP_RSQ:
            begin
                mul_a = r_reg[cnt_reg[1:0]];
                mul_b = r_reg[cnt_reg[1:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_asr = prod_reg >>> 30;
    assign prod_sh  = prod_asr[33:0];

    // square root trial, angle reduction, fold, cordic shifts
    assign sq_trial = root_reg + bit_reg;
    assign tp_k     = 39'(TWO_PI_Q32) << (3'd4 - cnt_reg[2:0]);

    always_comb
    begin
        fa0  = $signed({1'b0, a_reg[34:0]});
        fa1  = (fa0 > PI_Q32) ? fa0 - 36'(2 * PI_Q32) : fa0;
        fa2  = fa1;
        fneg = 1'b0;
        if (fa1 > HALF_PI_Q32)
        begin
            fa2  = fa1 - PI_Q32;
            fneg = 1'b1;
        end
        else if (fa1 < -HALF_PI_Q32)
        begin
            fa2  = fa1 + PI_Q32;
            fneg = 1'b1;
        end
    end

    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    assign at = $signed({4'b0000, atan_q30(cnt_reg[4:0])});

    // restoring divider, (num * 2^30) / nrm
    assign dnum    = (op_reg == OP_AXIS) ? 34'(g_reg[idx_reg]) : r_reg[idx_reg];
    assign dmag    = dnum[33] ? 34'(-dnum) : 34'(dnum);
    assign rem2    = {rem_reg, dsh_reg[30]};
    assign ddiff   = {1'b0, rem2} - {2'b00, nrm};
    assign div_res = dneg_reg ? -$signed({1'b0, qt_reg}) : $signed({1'b0, qt_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_GSQ;
            run_reg     <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pvld_reg    <= 1'b0;
            pidx_reg    <= '0;
            m_valid_reg <= 1'b0;
            period_reg  <= PERIOD_RESET;
            q_reg[0]    <= ONE_Q30;
            q_reg[1]    <= '0;
            q_reg[2]    <= '0;
            q_reg[3]    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            pvld_reg <= run_reg && mul_op && (cnt_reg < mul_k);
            pidx_reg <= cnt_reg[3:0];
            if (cmd.start)
            begin
                op_reg  <= cmd.op;
                run_reg <= 1'b1;
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else if (run_reg)
            begin
                if (done_c)
                begin
                    run_reg <= 1'b0;
                end
                else if ((op_reg == OP_AXIS || op_reg == OP_RNORM) && cnt_reg == DIV_LAST)
                begin
                    cnt_reg <= '0;
                    idx_reg <= idx_reg + 2'd1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            if (cmd.load && start_sequence)
            begin
                q_reg[0] <= ONE_Q30;
                q_reg[1] <= '0;
                q_reg[2] <= '0;
                q_reg[3] <= '0;
            end
            if (run_reg && op_reg == OP_RNORM && cnt_reg == DIV_LAST)
            begin
                q_reg[idx_reg] <= nrm_zero ? r_reg[idx_reg][31:0] : div_res;
            end
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                g_reg[i] <= g_in[i];
            end
        end
        if (cmd.emit)
        begin
            for (int i = 0; i < 4; i++)
            begin
                oq_reg[i] <= q_reg[i];
            end
        end
        if (cmd.start && (cmd.op == OP_GSQ || cmd.op == OP_RSQ))
        begin
            sq_reg <= '0;
        end
        if (cmd.start && cmd.op == OP_QMUL)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r_reg[i] <= '0;
            end
        end
        if (cmd.start && cmd.op == OP_SQRT)
        begin
            // last square is still in the product register
            v_reg    <= pvld_reg ? sq_reg + prod_reg[63:0] : sq_reg;
            root_reg <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        if (pvld_reg)
        begin
            unique case (op_reg)
                OP_GSQ, OP_RSQ:
                    sq_reg <= sq_reg + prod_reg[63:0];
                OP_ANGLE:
                    a_reg <= prod_reg[63:25];
                OP_PSCALE:
                    p_reg[2'(pidx_reg[1:0] + 2'd1)] <= prod_sh;
                OP_QMUL:
                begin
                    if (qmul_neg(pidx_reg[3:2], pidx_reg[1:0]))
                    begin
                        r_reg[pidx_reg[3:2]] <= r_reg[pidx_reg[3:2]] - prod_sh;
                    end
                    else
                    begin
                        r_reg[pidx_reg[3:2]] <= r_reg[pidx_reg[3:2]] + prod_sh;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (run_reg)
        begin
            unique case (op_reg)
                OP_SQRT:
                begin
                    if (cnt_reg < SQRT_STEPS)
                    begin
                        if (v_reg >= sq_trial)
                        begin
                            v_reg    <= v_reg - sq_trial;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                OP_REDUCE:
                begin
                    if (cnt_reg < REDUCE_STEPS)
                    begin
                        if (a_reg >= tp_k)
                        begin
                            a_reg <= a_reg - tp_k;
                        end
                    end
                    else
                    begin
                        z_reg   <= 34'(fa2 >>> 2);
                        neg_reg <= fneg;
                        x_reg   <= CORDIC_GAIN;
                        y_reg   <= '0;
                    end
                end
                OP_CORDIC:
                begin
                    if (cnt_reg < CORDIC_STAGES)
                    begin
                        if (!z_reg[33])
                        begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - at;
                        end
                        else
                        begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + at;
                        end
                    end
                    else
                    begin
                        p_reg[0] <= neg_reg ? -x_reg : x_reg;
                        s_reg    <= neg_reg ? -y_reg : y_reg;
                    end
                end
                OP_AXIS, OP_RNORM:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        dneg_reg <= dnum[33];
                        rem_reg  <= dmag[32:1];
                        dsh_reg  <= {dmag[0], 30'd0};
                        qt_reg   <= '0;
                    end
                    else if (cnt_reg < DIV_LAST)
                    begin
                        rem_reg <= ddiff[33] ? rem2[31:0] : ddiff[31:0];
                        dsh_reg <= {dsh_reg[29:0], 1'b0};
                        qt_reg  <= {qt_reg[29:0], !ddiff[33]};
                    end
                    else if (op_reg == OP_AXIS)
                    begin
                        axis_reg[idx_reg] <= div_res;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
